>>> rtl/core/signed_int_to_decimal_ascii_defines.svh
// Assertion macros shared by the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SITD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sitd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SITD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sitd: next-cycle check failed");

`endif

>>> rtl/core/sitd_pkg.sv
// Shared constants and types for the signed integer to decimal text converter.
package sitd_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int unsigned IDX_W      = $clog2(NUM_DIGITS);
  localparam int unsigned CNT_W      = $clog2(DATA_W);
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Finished conversion handed from the converter to the character emitter.
  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } conv_result_t;

endpackage

>>> rtl/core/sitd_dabble_step.sv
// One shift-and-add-3 step of the binary to BCD conversion.
module sitd_dabble_step (
  input  logic [sitd_pkg::BCD_W-1:0]  bcd,
  input  logic [sitd_pkg::DATA_W-1:0] mag,
  output logic [sitd_pkg::BCD_W-1:0]  bcd_next,
  output logic [sitd_pkg::DATA_W-1:0] mag_next
);

  logic [sitd_pkg::BCD_W-1:0] adjusted;

  // Each BCD digit of five or more is corrected by three before the shift.
  always_comb begin
    for (int i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] >= 4'd5) begin
        adjusted[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] =
          bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] + 4'd3;
      end else begin
        adjusted[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] =
          bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W];
      end
    end
  end

  // The binary magnitude shifts its top bit into the BCD register.
  assign bcd_next = {adjusted[sitd_pkg::BCD_W-2:0], mag[sitd_pkg::DATA_W-1]};
  assign mag_next = {mag[sitd_pkg::DATA_W-2:0], 1'b0};

endmodule

>>> rtl/core/sitd_convert.sv
// Iterative binary to BCD converter: one dabble step per cycle over the magnitude.
module sitd_convert (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sitd_pkg::DATA_W-1:0]   value,
  output logic                          busy,
  output logic                          done,
  output sitd_pkg::conv_result_t        result
);

  logic [sitd_pkg::DATA_W-1:0] mag;
  logic [sitd_pkg::BCD_W-1:0]  bcd;
  logic                        neg;
  logic [sitd_pkg::CNT_W-1:0]  cnt;
  logic [sitd_pkg::BCD_W-1:0]  bcd_next;
  logic [sitd_pkg::DATA_W-1:0] mag_next;

  sitd_dabble_step u_step (
    .bcd      (bcd),
    .mag      (mag),
    .bcd_next (bcd_next),
    .mag_next (mag_next)
  );

  // Control: a run of one step per input bit, then a single done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == sitd_pkg::CNT_W'(sitd_pkg::DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the magnitude is taken in unsigned arithmetic, so the most
  // negative value converts like any other.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= value[sitd_pkg::DATA_W-1];
      mag <= value[sitd_pkg::DATA_W-1] ? (sitd_pkg::DATA_W'(0) - value) : value;
      bcd <= '0;
    end else if (busy) begin
      mag <= mag_next;
      bcd <= bcd_next;
    end
  end

  assign result.neg = neg;
  assign result.bcd = bcd;

endmodule

>>> rtl/core/sitd_emit.sv
// Character emitter: sign, then significant digits, through an output register.
module sitd_emit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  sitd_pkg::conv_result_t            result,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sitd_pkg::CHAR_W-1:0]       character,
  output logic                              last
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t                      state;
  logic                        sign_pending;
  logic [sitd_pkg::IDX_W-1:0]  idx;
  logic [sitd_pkg::BCD_W-1:0]  bcd;
  logic [sitd_pkg::IDX_W-1:0]  top;
  logic [sitd_pkg::DIGIT_W-1:0] digit;
  logic                        advance;

  // Position of the most significant non-zero digit; zero gives position 0.
  always_comb begin
    top = '0;
    for (int i = 1; i < sitd_pkg::NUM_DIGITS; i++) begin
      if (result.bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W] != '0) begin
        top = sitd_pkg::IDX_W'(i);
      end
    end
  end

  // Digit currently pointed at.
  always_comb begin
    digit = '0;
    for (int i = 0; i < sitd_pkg::NUM_DIGITS; i++) begin
      if (idx == sitd_pkg::IDX_W'(i)) begin
        digit = bcd[i*sitd_pkg::DIGIT_W +: sitd_pkg::DIGIT_W];
      end
    end
  end

  // The output register may take a new word when empty or being drained.
  assign advance = !out_valid || !out_stall;
  assign busy    = (state != ST_IDLE);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      sign_pending <= 1'b0;
      idx          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (advance) begin
            out_valid <= 1'b0;
          end
          if (load) begin
            state        <= ST_EMIT;
            sign_pending <= result.neg;
            idx          <= top;
            bcd          <= result.bcd;
          end
        end
        ST_EMIT: begin
          if (advance) begin
            out_valid <= 1'b1;
            if (sign_pending) begin
              sign_pending <= 1'b0;
              character    <= sitd_pkg::CHAR_MINUS;
              last         <= 1'b0;
            end else begin
              character <= sitd_pkg::CHAR_ZERO + sitd_pkg::CHAR_W'(digit);
              last      <= (idx == '0);
              if (idx == '0) begin
                state <= ST_IDLE;
              end else begin
                idx <= idx - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/signed_int_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per output word.
//
// Each accepted value is converted by a shift-and-add-3 unit that handles one
// magnitude bit per cycle; the characters then leave one per cycle when the
// output is not stalled: a '-' first for a negative value, then the
// significant digits, most significant first, with last set on the final
// digit. Zero gives the single character '0'. A text has up to 11 output
// words; in_stall stays high from acceptance until the final character has
// been loaded into the output register, which may still wait there while the
// next conversion runs.
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [sitd_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sitd_pkg::CHAR_W-1:0]       character,
  output logic                              last
);

  logic                   start;
  logic                   conv_busy;
  logic                   conv_done;
  logic                   emit_busy;
  sitd_pkg::conv_result_t conv_result;

  // One value in flight: the input waits while either part is at work.
  assign in_stall = conv_busy || conv_done || emit_busy;
  assign start    = in_valid && !in_stall;

  sitd_convert u_convert (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .value  (value),
    .busy   (conv_busy),
    .done   (conv_done),
    .result (conv_result)
  );

  sitd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (conv_done),
    .result    (conv_result),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  // An accepted value keeps the input closed in the following cycle.
  `SITD_ASSERT_NEXT(a_busy_after_accept, clk, rst, start, in_stall)
  // A sign character is never the end of a text.
  `SITD_ASSERT_SAME(a_sign_not_last, clk, rst, out_valid && (character == sitd_pkg::CHAR_MINUS), !last)
  // The input opens only once the pending text is complete.
  `SITD_ASSERT_SAME(a_open_only_between_texts, clk, rst, !in_stall, !out_valid || last)
  // Characters of one text follow without gaps.
  `SITD_ASSERT_NEXT(a_text_contiguous, clk, rst, out_valid && !out_stall && !last, out_valid)

endmodule
